// ===== hdl/qes_pkg.sv =====
package qes_pkg;

   localparam int COEF_W        = 32;
   localparam int MAG_W         = 32;
   localparam int TOL_W         = 16;
   localparam int PROD_W        = 2 * MAG_W;
   localparam int DISC_W        = PROD_W + 2;
   localparam int ROOT_W        = DISC_W / 2;
   localparam int NMAG_W        = ROOT_W + 1;
   localparam int DEN_W         = MAG_W + 1;
   localparam int COUNT_W       = 2;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REQ_DATA_W    = 3 * COEF_W;
   localparam int RSP_FIELDS_W  = COUNT_W + 2 * COEF_W + 1;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [COUNT_W-1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2,
      CNT_INF  = 2'd3
   } count_type;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_INF,
      MODE_LIN,
      MODE_DBL,
      MODE_TWO
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic              na;
      logic              nb;
      logic              nc;
      logic [MAG_W-1:0]  ma;
      logic [MAG_W-1:0]  mb;
      logic [MAG_W-1:0]  mc;
   } sq_side_type;

   typedef struct packed {
      mode_type mode;
      logic     nneg;
      logic     dneg;
   } dv_side_type;

endpackage

// ===== hdl/qes_isqrt.sv =====
module qes_isqrt #(
   parameter int IN_W   = qes_pkg::DISC_W,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_radicand,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int RW = IN_W / 2;

   logic              valid_ff [RW];
   logic [RW+1:0]     rem_ff   [RW];
   logic [RW-1:0]     root_ff  [RW];
   logic [IN_W-1:0]   num_ff   [RW];
   logic [SIDE_W-1:0] side_ff  [RW];

   // one result bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic              v_prev;
      logic [RW+1:0]     rem_prev;
      logic [RW-1:0]     root_prev;
      logic [IN_W-1:0]   num_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RW+1:0]     rem_sh;
      logic [RW+1:0]     trial;
      logic [RW+1:0]     rem_in;
      logic [RW-1:0]     root_in;
      logic [IN_W-1:0]   num_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign num_prev  = in_radicand;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[RW-1:0], num_prev[IN_W-1 -: 2]};
         trial  = {root_prev, 2'b01};
         num_in = {num_prev[IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            num_ff[k]  <= num_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

// ===== hdl/qes_div.sv =====
module qes_div #(
   parameter int NUM_W  = 51,
   parameter int DEN_W  = qes_pkg::DEN_W,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]  out_side
);

   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [NUM_W-1:0]  quot_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    rem_sh;
      logic [DEN_W:0]    rem_sub;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quot_in;
      logic [NUM_W-1:0]  num_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign den_prev  = in_den;
         assign num_prev  = in_num;
         assign quot_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign quot_prev = quot_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev, num_prev[NUM_W-1]};
         rem_sub = rem_sh - {1'b0, den_prev};
         num_in  = {num_prev[NUM_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_prev}) begin
            rem_in  = rem_sub[DEN_W-1:0];
            quot_in = {quot_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DEN_W-1:0];
            quot_in = {quot_prev[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            num_ff[k]  <= num_in;
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== hdl/quadratic_equation_solver_unit.sv =====
// Real roots of a*x^2 + b*x + c = 0, signed fixed point with FRAC_BITS fraction bits.
// Input channel req_*: one item holds coef_a, coef_b, coef_c.
// Result channel rsp_*: one item per input item, in order: root_count,
// root_first, root_second, saturated.
// csr_we/csr_wdata load zero_tolerance; write it only while the pipe is empty.
// Throughput: one item per cycle, no gaps, as long as rsp_tready does not stall the pipe.
// Stages from accept to rsp_tvalid: four front stages (magnitudes, products,
// discriminant, case select), 33 square-root stages, three numerator stages, one
// divider stage per quotient bit (35 + FRAC_BITS), and the output register.
// The whole pipe advances on one enable; when rsp_tready is low with a result
// waiting, every stage holds and req_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets zero_tolerance to 0.
module quadratic_equation_solver_unit #(
   parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coef_a, coef_b, coef_c
   input  logic [qes_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // root_count, root_first, root_second, saturated, zero pad
   output logic [qes_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [qes_pkg::TOL_W-1:0]         csr_wdata
);

   localparam int MW    = qes_pkg::MAG_W;
   localparam int CW    = qes_pkg::COEF_W;
   localparam int DW    = qes_pkg::DISC_W;
   localparam int RW    = qes_pkg::ROOT_W;
   localparam int NW    = qes_pkg::NMAG_W;
   localparam int DENW  = qes_pkg::DEN_W;
   localparam int NUM_W = NW + FRAC_BITS + 1;
   localparam int SQS_W = $bits(qes_pkg::sq_side_type);
   localparam int DVS_W = $bits(qes_pkg::dv_side_type);
   localparam int PAD_W = qes_pkg::RSP_DATA_W - qes_pkg::RSP_FIELDS_W;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [qes_pkg::TOL_W-1:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // stage 1: magnitudes
   logic           s1_valid_ff;
   logic           s1_na_ff, s1_nb_ff, s1_nc_ff;
   logic [MW-1:0]  s1_ma_ff, s1_mb_ff, s1_mc_ff;
   logic [CW-1:0]  ca, cb, cc;
   assign ca = req_tdata[CW-1:0];
   assign cb = req_tdata[2*CW-1:CW];
   assign cc = req_tdata[3*CW-1:2*CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_na_ff <= ca[CW-1];
         s1_nb_ff <= cb[CW-1];
         s1_nc_ff <= cc[CW-1];
         s1_ma_ff <= ca[CW-1] ? (~ca + 1'b1) : ca;
         s1_mb_ff <= cb[CW-1] ? (~cb + 1'b1) : cb;
         s1_mc_ff <= cc[CW-1] ? (~cc + 1'b1) : cc;
      end
   end

   // stage 2: products and zero tests
   logic                          s2_valid_ff;
   logic                          s2_na_ff, s2_nb_ff, s2_nc_ff;
   logic                          s2_az_ff, s2_bz_ff, s2_cz_ff;
   logic [MW-1:0]                 s2_ma_ff, s2_mb_ff, s2_mc_ff;
   logic [qes_pkg::PROD_W-1:0]    s2_p_ff, s2_b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_na_ff <= s1_na_ff;
         s2_nb_ff <= s1_nb_ff;
         s2_nc_ff <= s1_nc_ff;
         s2_ma_ff <= s1_ma_ff;
         s2_mb_ff <= s1_mb_ff;
         s2_mc_ff <= s1_mc_ff;
         s2_az_ff <= s1_ma_ff <= MW'(tol_ff);
         s2_bz_ff <= s1_mb_ff <= MW'(tol_ff);
         s2_cz_ff <= s1_mc_ff <= MW'(tol_ff);
         s2_p_ff  <= s1_ma_ff * s1_mc_ff;
         s2_b2_ff <= s1_mb_ff * s1_mb_ff;
      end
   end

   // stage 3: discriminant as sign and magnitude
   logic           s3_valid_ff;
   logic           s3_na_ff, s3_nb_ff, s3_nc_ff;
   logic           s3_az_ff, s3_bz_ff, s3_cz_ff;
   logic [MW-1:0]  s3_ma_ff, s3_mb_ff, s3_mc_ff;
   logic [DW-1:0]  s3_d_ff;
   logic           s3_dneg_ff;
   logic [DW-1:0]  b2_x, four_x, d_in;
   logic           dneg_in;

   always_comb begin
      b2_x   = DW'(s2_b2_ff);
      four_x = {s2_p_ff, 2'b00};
      dneg_in = 1'b0;
      if ((s2_na_ff != s2_nc_ff) && (s2_p_ff != '0)) begin
         d_in = b2_x + four_x;
      end else if (b2_x >= four_x) begin
         d_in = b2_x - four_x;
      end else begin
         d_in    = four_x - b2_x;
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_na_ff   <= s2_na_ff;
         s3_nb_ff   <= s2_nb_ff;
         s3_nc_ff   <= s2_nc_ff;
         s3_az_ff   <= s2_az_ff;
         s3_bz_ff   <= s2_bz_ff;
         s3_cz_ff   <= s2_cz_ff;
         s3_ma_ff   <= s2_ma_ff;
         s3_mb_ff   <= s2_mb_ff;
         s3_mc_ff   <= s2_mc_ff;
         s3_d_ff    <= d_in;
         s3_dneg_ff <= dneg_in;
      end
   end

   // stage 4: case select
   logic                  s4_valid_ff;
   logic [DW-1:0]         s4_d_ff;
   qes_pkg::sq_side_type  s4_side_ff;
   qes_pkg::sq_side_type  side4_in;
   logic                  dz;

   always_comb begin
      dz = s3_d_ff <= (DW'(tol_ff) << FRAC_BITS);
      side4_in.na = s3_na_ff;
      side4_in.nb = s3_nb_ff;
      side4_in.nc = s3_nc_ff;
      side4_in.ma = s3_ma_ff;
      side4_in.mb = s3_mb_ff;
      side4_in.mc = s3_mc_ff;
      if (s3_az_ff) begin
         if (!s3_bz_ff) begin
            side4_in.mode = qes_pkg::MODE_LIN;
         end else if (s3_cz_ff) begin
            side4_in.mode = qes_pkg::MODE_INF;
         end else begin
            side4_in.mode = qes_pkg::MODE_NONE;
         end
      end else if (dz) begin
         side4_in.mode = qes_pkg::MODE_DBL;
      end else if (!s3_dneg_ff) begin
         side4_in.mode = qes_pkg::MODE_TWO;
      end else begin
         side4_in.mode = qes_pkg::MODE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_d_ff    <= s3_d_ff;
         s4_side_ff <= side4_in;
      end
   end

   // square root
   logic                  sq_valid;
   logic [RW-1:0]         sq_root;
   logic [SQS_W-1:0]      sq_side_vec;
   qes_pkg::sq_side_type  sq_side;

   qes_isqrt #(
      .IN_W   (DW),
      .SIDE_W (SQS_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s4_valid_ff),
      .in_radicand (s4_d_ff),
      .in_side     (s4_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side_vec)
   );

   assign sq_side = qes_pkg::sq_side_type'(sq_side_vec);

   // p1: -b +/- sqrt(D)
   logic                  p1_valid_ff;
   qes_pkg::sq_side_type  p1_side_ff;
   logic [NW:0]           p1_n1_ff, p1_n2_ff;
   logic [NW:0]           mb_x, minus_b, s_x;

   always_comb begin
      mb_x    = (NW+1)'(sq_side.mb);
      minus_b = sq_side.nb ? mb_x : (~mb_x + 1'b1);
      s_x     = (NW+1)'(sq_root);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= sq_side;
         p1_n1_ff   <= minus_b + s_x;
         p1_n2_ff   <= minus_b - s_x;
      end
   end

   // p2: numerator and denominator per case
   logic                p2_valid_ff;
   logic [NW-1:0]       p2_nmag1_ff, p2_nmag2_ff;
   logic [DENW-1:0]     p2_dmag_ff;
   qes_pkg::dv_side_type p2_side_ff;
   logic                p2_nneg2_ff;
   logic [NW-1:0]       nmag1_in, nmag2_in;
   logic [DENW-1:0]     dmag_in;
   qes_pkg::dv_side_type side2_in;
   logic                nneg2_in;
   logic [NW:0]         n1_abs, n2_abs;

   always_comb begin
      n1_abs = p1_n1_ff[NW] ? (~p1_n1_ff + 1'b1) : p1_n1_ff;
      n2_abs = p1_n2_ff[NW] ? (~p1_n2_ff + 1'b1) : p1_n2_ff;
      side2_in.mode = p1_side_ff.mode;
      nmag1_in      = '0;
      nmag2_in      = '0;
      dmag_in       = '0;
      side2_in.nneg = 1'b0;
      side2_in.dneg = 1'b0;
      nneg2_in      = 1'b0;
      unique case (p1_side_ff.mode)
         qes_pkg::MODE_LIN: begin
            nmag1_in      = NW'(p1_side_ff.mc);
            side2_in.nneg = !p1_side_ff.nc;
            dmag_in       = DENW'(p1_side_ff.mb);
            side2_in.dneg = p1_side_ff.nb;
         end
         qes_pkg::MODE_DBL: begin
            nmag1_in      = NW'(p1_side_ff.mb);
            side2_in.nneg = !p1_side_ff.nb && (p1_side_ff.mb != '0);
            dmag_in       = {p1_side_ff.ma, 1'b0};
            side2_in.dneg = p1_side_ff.na;
         end
         qes_pkg::MODE_TWO: begin
            nmag1_in      = n1_abs[NW-1:0];
            side2_in.nneg = p1_n1_ff[NW];
            nmag2_in      = n2_abs[NW-1:0];
            nneg2_in      = p1_n2_ff[NW];
            dmag_in       = {p1_side_ff.ma, 1'b0};
            side2_in.dneg = p1_side_ff.na;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_nmag1_ff <= nmag1_in;
         p2_nmag2_ff <= nmag2_in;
         p2_dmag_ff  <= dmag_in;
         p2_side_ff  <= side2_in;
         p2_nneg2_ff <= nneg2_in;
      end
   end

   // p3: scaled numerator with half-divisor for rounding
   logic                 p3_valid_ff;
   logic [NUM_W-1:0]     p3_num1_ff, p3_num2_ff;
   logic [DENW-1:0]      p3_dmag_ff;
   qes_pkg::dv_side_type p3_side_ff;
   logic                 p3_nneg2_ff;
   logic [NUM_W-1:0]     half_den;

   assign half_den = NUM_W'(p2_dmag_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_num1_ff  <= (NUM_W'(p2_nmag1_ff) << FRAC_BITS) + half_den;
         p3_num2_ff  <= (NUM_W'(p2_nmag2_ff) << FRAC_BITS) + half_den;
         p3_dmag_ff  <= p2_dmag_ff;
         p3_side_ff  <= p2_side_ff;
         p3_nneg2_ff <= p2_nneg2_ff;
      end
   end

   // dividers
   logic                 dv1_valid, dv2_valid;
   logic [NUM_W-1:0]     q1, q2;
   logic [DVS_W-1:0]     dv1_side_vec;
   logic [0:0]           dv2_side_vec;
   qes_pkg::dv_side_type dv1_side;

   qes_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DENW),
      .SIDE_W (DVS_W)
   ) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_valid_ff),
      .in_num    (p3_num1_ff),
      .in_den    (p3_dmag_ff),
      .in_side   (p3_side_ff),
      .out_valid (dv1_valid),
      .out_quot  (q1),
      .out_side  (dv1_side_vec)
   );

   qes_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DENW),
      .SIDE_W (1)
   ) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_valid_ff),
      .in_num    (p3_num2_ff),
      .in_den    (p3_dmag_ff),
      .in_side   (p3_nneg2_ff),
      .out_valid (dv2_valid),
      .out_quot  (q2),
      .out_side  (dv2_side_vec)
   );

   assign dv1_side = qes_pkg::dv_side_type'(dv1_side_vec);

   // sign and saturation: {sat, root}
   function automatic logic [CW:0] fix_root(input logic [NUM_W-1:0] q,
                                             input logic nneg, input logic dneg);
      logic [CW:0] r;
      r = '0;
      if (nneg == dneg) begin
         if (q > NUM_W'(32'h7FFF_FFFF)) begin
            r = {1'b1, 32'h7FFF_FFFF};
         end else begin
            r = {1'b0, q[CW-1:0]};
         end
      end else begin
         if (q > NUM_W'(32'h8000_0000)) begin
            r = {1'b1, 32'h8000_0000};
         end else begin
            r = {1'b0, ~q[CW-1:0] + 1'b1};
         end
      end
      return r;
   endfunction

   logic [CW:0]          fr1, fr2;
   qes_pkg::count_type   count_in;
   logic [CW-1:0]        r1_in, r2_in;
   logic                 sat_in;

   always_comb begin
      fr1      = fix_root(q1, dv1_side.nneg, dv1_side.dneg);
      fr2      = fix_root(q2, dv2_side_vec[0], dv1_side.dneg);
      count_in = qes_pkg::CNT_NONE;
      r1_in    = '0;
      r2_in    = '0;
      sat_in   = 1'b0;
      unique case (dv1_side.mode)
         qes_pkg::MODE_INF: begin
            count_in = qes_pkg::CNT_INF;
         end
         qes_pkg::MODE_LIN, qes_pkg::MODE_DBL: begin
            count_in = qes_pkg::CNT_ONE;
            r1_in    = fr1[CW-1:0];
            sat_in   = fr1[CW];
         end
         qes_pkg::MODE_TWO: begin
            count_in = qes_pkg::CNT_TWO;
            r1_in    = fr1[CW-1:0];
            r2_in    = fr2[CW-1:0];
            sat_in   = fr1[CW] | fr2[CW];
         end
         default: begin
         end
      endcase
   end

   // output register
   logic                         rsp_valid_ff;
   logic [qes_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv1_valid && dv2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, sat_in, r2_in, r1_in, count_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
